[rtl/at_response_parser_core_defines.svh]
// Assertion macros for the AT response parser checks.
// Included by the checker module; no other dependencies.
`ifndef AT_RESPONSE_PARSER_CORE_DEFINES_SVH
`define AT_RESPONSE_PARSER_CORE_DEFINES_SVH
`define ATP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("at_response_parser_core check failed");
`define ATP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("at_response_parser_core check failed");
`endif

[rtl/atp_pkg.sv]
// Shared types, codes, match texts and helper functions of the AT response parser.
// Used by every module of the block; depends on nothing else.
package atp_pkg;

  localparam int FieldMax = 32;
  localparam int QDepth = 2;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  localparam logic [2:0] KindCpin  = 3'd0;
  localparam logic [2:0] KindCcid  = 3'd1;
  localparam logic [2:0] KindCsq   = 3'd2;
  localparam logic [2:0] KindCgatt = 3'd3;
  localparam logic [2:0] KindCstt  = 3'd4;
  localparam logic [2:0] KindCifsr = 3'd5;

  localparam logic OutChar  = 1'b0;
  localparam logic OutFinal = 1'b1;

  localparam logic [7:0] Cr    = 8'h0d;
  localparam logic [7:0] Lf    = 8'h0a;
  localparam logic [7:0] Comma = 8'h2c;
  localparam logic [7:0] Space = 8'h20;
  localparam logic [7:0] Nul   = 8'h00;
  localparam logic [7:0] Zero  = 8'h30;
  localparam logic [7:0] Nine  = 8'h39;

  localparam logic [3:0] ErrLen = 4'd9;
  localparam logic [3:0] OkLen  = 4'd6;

  localparam logic [79:0] ErrText  = {Cr, Lf, "ERROR", Cr, Lf, 8'h00};
  localparam logic [79:0] OkText   = {Cr, Lf, "OK", Cr, Lf, 32'h0};
  localparam logic [79:0] PfxCpin  = {Cr, Lf, "+CPIN: ", 8'h00};
  localparam logic [79:0] PfxCcid  = {Cr, Lf, 64'h0};
  localparam logic [79:0] PfxCsq   = {Cr, Lf, "+CSQ: ", 16'h0};
  localparam logic [79:0] PfxCgatt = {Cr, Lf, "+CGATT: "};
  localparam logic [79:0] PfxCstt  = {Cr, Lf, "+CSTT: ", 8'h00};

  typedef enum logic [3:0] {
    PhIdle,
    PhPrefix,
    PhField,
    PhExpLf,
    PhTrailer,
    PhNum1,
    PhSpace,
    PhNum2,
    PhNumG,
    PhWaitErr
  } atp_phase_e;

  typedef enum logic [1:0] {
    StOk,
    StError,
    StMalformed,
    StNoTrailer
  } atp_status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       is_digit;
    logic       is_delim;
    logic [3:0] digit;
  } atp_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [1:0]  field_number;
    logic [4:0]  char_pos;
    logic [7:0]  char_value;
    atp_status_e status;
    logic [7:0]  rssi_value;
    logic [7:0]  ber_value;
    logic [7:0]  attach_value;
  } atp_result_t;

  function automatic logic [7:0] text_char(input logic [79:0] text, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 10; i++) begin
      if (pos == 4'(i)) begin
        c = text[79 - 8 * i -: 8];
      end
    end
    return c;
  endfunction

  function automatic logic [79:0] prefix_text(input logic [2:0] kind);
    logic [79:0] t;
    case (kind)
      KindCpin:  t = PfxCpin;
      KindCcid:  t = PfxCcid;
      KindCsq:   t = PfxCsq;
      KindCgatt: t = PfxCgatt;
      KindCstt:  t = PfxCstt;
      KindCifsr: t = PfxCcid;
      default:   t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] prefix_len(input logic [2:0] kind);
    logic [3:0] n;
    case (kind)
      KindCpin:  n = 4'd9;
      KindCcid:  n = 4'd2;
      KindCsq:   n = 4'd8;
      KindCgatt: n = 4'd10;
      KindCstt:  n = 4'd9;
      KindCifsr: n = 4'd2;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/atp_front.sv]
// Input side of the AT response parser: accepts bytes, classifies them and
// queues them for the parser. Depends on atp_pkg.
module atp_front import atp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  logic [7:0] rx_byte_i,
  input  logic      frame_start_i,
  output logic      item_valid_o,
  output atp_item_t item_o,
  input  logic      item_take_i
);

  atp_item_t            mem_q [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]     count_q, count_d;
  atp_item_t            item_in;
  logic                 wr_en;
  logic                 rd_en;

  always_comb begin
    item_in.rx_byte     = rx_byte_i;
    item_in.frame_start = frame_start_i;
    item_in.is_digit    = (rx_byte_i >= Zero) && (rx_byte_i <= Nine);
    item_in.is_delim    = (rx_byte_i == Nul) || (rx_byte_i == Comma) ||
                          (rx_byte_i == Cr) || (rx_byte_i == Lf);
    item_in.digit       = 4'(rx_byte_i - Zero);
  end

  assign full         = (count_q == QCntW'(QDepth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = item_take_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

[rtl/atp_outq.sv]
// Result queue of the AT response parser: holds finished results until the
// consumer takes them. Depends on atp_pkg.
module atp_outq import atp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_valid_i,
  input  atp_result_t res_i,
  output logic        full_o,
  output logic        empty_o,
  output atp_result_t res_o,
  input  logic        pop_i
);

  atp_result_t      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             wr_en;
  logic             rd_en;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign res_o   = mem_q[rd_ptr_q];
  assign wr_en   = res_valid_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

[rtl/atp_back.sv]
// Parser core of the AT response parser: steps the response state machine one classified
// byte per cycle while the result queue has room; produces character and status results. Depends on atp_pkg.
module atp_back import atp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  cfg_kind_i,
  input  logic        item_valid_i,
  input  atp_item_t   item_i,
  output logic        item_take_o,
  input  logic        res_full_i,
  output logic        res_valid_o,
  output atp_result_t res_o
);

  atp_phase_e  phase_q, phase_d;
  logic [3:0]  match_pos_q, match_pos_d;
  logic [4:0]  field_count_q, field_count_d;
  logic [1:0]  field_index_q, field_index_d;
  logic        err_ok_q, err_ok_d;
  logic [3:0]  err_pos_q, err_pos_d;
  logic [7:0]  number_acc_q, number_acc_d;
  logic [7:0]  first_number_q, first_number_d;
  logic [2:0]  kind_q, kind_d;
  logic        fail;
  logic        emit;
  logic        char_emit;
  atp_status_e emit_status;
  logic [7:0]  b;
  logic [7:0]  term;

  assign item_take_o = item_valid_i && !res_full_i;
  assign b           = item_i.rx_byte;

  always_comb begin
    phase_d        = phase_q;
    match_pos_d    = match_pos_q;
    field_count_d  = field_count_q;
    field_index_d  = field_index_q;
    err_ok_d       = err_ok_q;
    err_pos_d      = err_pos_q;
    number_acc_d   = number_acc_q;
    first_number_d = first_number_q;
    kind_d         = kind_q;
    fail           = 1'b0;
    emit           = 1'b0;
    char_emit      = 1'b0;
    emit_status    = StMalformed;
    term           = Cr;
    res_o          = '0;

    if (item_take_o && (item_i.frame_start || phase_q != PhIdle)) begin
      if (item_i.frame_start) begin
        phase_d        = PhPrefix;
        match_pos_d    = '0;
        field_count_d  = '0;
        field_index_d  = '0;
        err_ok_d       = 1'b1;
        err_pos_d      = '0;
        number_acc_d   = '0;
        first_number_d = '0;
        kind_d         = cfg_kind_i;
      end

      if (err_ok_d) begin
        if (err_pos_d < ErrLen && b == text_char(ErrText, err_pos_d)) begin
          err_pos_d = err_pos_d + 1'b1;
          if (err_pos_d == ErrLen) begin
            emit        = 1'b1;
            emit_status = StError;
          end
        end else begin
          err_ok_d = 1'b0;
        end
      end

      if (!emit) begin
        if (phase_d == PhWaitErr) begin
          if (!err_ok_d) begin
            emit        = 1'b1;
            emit_status = StMalformed;
          end
        end else begin
          case (phase_d)
            PhPrefix: begin
              if (kind_d > KindCifsr || match_pos_d >= prefix_len(kind_d) ||
                  b != text_char(prefix_text(kind_d), match_pos_d)) begin
                fail = 1'b1;
              end else begin
                match_pos_d = match_pos_d + 1'b1;
                if (match_pos_d == prefix_len(kind_d)) begin
                  match_pos_d  = '0;
                  number_acc_d = '0;
                  if (kind_d == KindCsq) begin
                    phase_d = PhNum1;
                  end else if (kind_d == KindCgatt) begin
                    phase_d = PhNumG;
                  end else begin
                    phase_d       = PhField;
                    field_index_d = '0;
                    field_count_d = '0;
                  end
                end
              end
            end
            PhField: begin
              term = (kind_d == KindCstt && field_index_d < 2'd2) ? Comma : Cr;
              if (!item_i.is_delim && field_count_d < 5'(FieldMax - 1)) begin
                char_emit          = 1'b1;
                res_o.out_kind     = OutChar;
                res_o.field_number = field_index_d;
                res_o.char_pos     = field_count_d;
                res_o.char_value   = b;
                field_count_d      = field_count_d + 1'b1;
              end else if (b != term) begin
                fail = 1'b1;
              end else if (term == Comma) begin
                field_index_d = field_index_d + 1'b1;
                field_count_d = '0;
              end else begin
                phase_d = PhExpLf;
              end
            end
            PhExpLf: begin
              if (b != Lf) begin
                fail = 1'b1;
              end else if (kind_d == KindCstt || kind_d == KindCifsr) begin
                emit        = 1'b1;
                emit_status = StNoTrailer;
              end else begin
                phase_d     = PhTrailer;
                match_pos_d = '0;
              end
            end
            PhTrailer: begin
              if (match_pos_d >= OkLen || b != text_char(OkText, match_pos_d)) begin
                fail = 1'b1;
              end else begin
                match_pos_d = match_pos_d + 1'b1;
                if (match_pos_d == OkLen) begin
                  emit        = 1'b1;
                  emit_status = StOk;
                end
              end
            end
            PhNum1: begin
              if (item_i.is_digit) begin
                number_acc_d = 8'(number_acc_d * 8'd10 + {4'h0, item_i.digit});
              end else if (b != Comma) begin
                fail = 1'b1;
              end else begin
                first_number_d = number_acc_d;
                number_acc_d   = '0;
                phase_d        = PhSpace;
              end
            end
            PhSpace, PhNum2: begin
              if (phase_d == PhSpace && b == Space) begin
                phase_d = PhNum2;
              end else if (item_i.is_digit) begin
                phase_d      = PhNum2;
                number_acc_d = 8'(number_acc_d * 8'd10 + {4'h0, item_i.digit});
              end else if (b != Cr) begin
                fail = 1'b1;
              end else begin
                phase_d = PhExpLf;
              end
            end
            PhNumG: begin
              if (item_i.is_digit) begin
                number_acc_d = 8'(number_acc_d * 8'd10 + {4'h0, item_i.digit});
              end else begin
                emit        = 1'b1;
                emit_status = StNoTrailer;
              end
            end
            default: begin
              fail = 1'b1;
            end
          endcase

          if (fail) begin
            if (err_ok_d) begin
              phase_d = PhWaitErr;
            end else begin
              emit        = 1'b1;
              emit_status = StMalformed;
            end
          end
        end
      end

      if (emit) begin
        phase_d        = PhIdle;
        res_o          = '0;
        res_o.out_kind = OutFinal;
        res_o.status   = emit_status;
        if (emit_status == StOk || emit_status == StNoTrailer) begin
          if (kind_d == KindCsq) begin
            res_o.rssi_value = first_number_d;
            res_o.ber_value  = number_acc_d;
          end else if (kind_d == KindCgatt) begin
            res_o.attach_value = number_acc_d;
          end
        end
      end
    end
  end

  assign res_valid_o = emit || char_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdle;
      match_pos_q    <= '0;
      field_count_q  <= '0;
      field_index_q  <= '0;
      err_ok_q       <= 1'b1;
      err_pos_q      <= '0;
      number_acc_q   <= '0;
      first_number_q <= '0;
      kind_q         <= KindCpin;
    end else begin
      phase_q        <= phase_d;
      match_pos_q    <= match_pos_d;
      field_count_q  <= field_count_d;
      field_index_q  <= field_index_d;
      err_ok_q       <= err_ok_d;
      err_pos_q      <= err_pos_d;
      number_acc_q   <= number_acc_d;
      first_number_q <= first_number_d;
      kind_q         <= kind_d;
    end
  end

endmodule

[rtl/at_response_parser_core.sv]
// An accepted byte is written into the input queue; the parser state machine reads it
// from there and writes any result into the result queue, whose head drives the ports.
// Throughput: one byte per cycle, set by the parser state machine stepping one byte
// per cycle while the result queue has room; a two-entry queue per side absorbs stalls.
// Reset: rst_ni is asynchronous and active low; it empties both queues, returns the
// parser to idle and clears the response kind register to zero.
// Depends on atp_pkg, atp_front, atp_back and atp_outq.
module at_response_parser_core import atp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] expected_response_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_start_i,
  output logic       empty,
  input  logic       pop,
  output logic       out_kind_o,
  output logic [1:0] field_number_o,
  output logic [4:0] char_pos_o,
  output logic [7:0] char_value_o,
  output logic [1:0] status_o,
  output logic [7:0] rssi_value_o,
  output logic [7:0] ber_value_o,
  output logic [7:0] attach_value_o
);

  logic [2:0]  expected_response_q;
  logic        item_valid;
  atp_item_t   item;
  logic        item_take;
  logic        res_full;
  logic        res_valid;
  atp_result_t res_in;
  atp_result_t res_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_response_q <= KindCpin;
    end else if (cfg_valid_i && cfg_ready_o) begin
      expected_response_q <= expected_response_i;
    end
  end

  atp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_take_i   (item_take)
  );

  atp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_kind_i   (expected_response_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_full_i   (res_full),
    .res_valid_o  (res_valid),
    .res_o        (res_in)
  );

  atp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_in),
    .full_o      (res_full),
    .empty_o     (empty),
    .res_o       (res_head),
    .pop_i       (pop)
  );

  assign out_kind_o     = res_head.out_kind;
  assign field_number_o = res_head.field_number;
  assign char_pos_o     = res_head.char_pos;
  assign char_value_o   = res_head.char_value;
  assign status_o       = res_head.status;
  assign rssi_value_o   = res_head.rssi_value;
  assign ber_value_o    = res_head.ber_value;
  assign attach_value_o = res_head.attach_value;

endmodule

[rtl/atp_checker.sv]
// Port-level checks for at_response_parser_core and the bind that attaches them.
// Depends on atp_pkg and at_response_parser_core_defines.svh.
`include "at_response_parser_core_defines.svh"

module atp_checker import atp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic       empty,
  input logic       pop,
  input logic       out_kind_o,
  input logic [1:0] field_number_o,
  input logic [4:0] char_pos_o,
  input logic [7:0] char_value_o,
  input logic [1:0] status_o,
  input logic [7:0] rssi_value_o,
  input logic [7:0] ber_value_o,
  input logic [7:0] attach_value_o
);

  `ATP_ASSERT_IMP(a_char_clean, !empty && out_kind_o == OutChar, status_o == StOk && rssi_value_o == 8'h00 && ber_value_o == 8'h00 && attach_value_o == 8'h00)
  `ATP_ASSERT_IMP(a_final_clean, !empty && out_kind_o == OutFinal, field_number_o == 2'd0 && char_pos_o == 5'd0 && char_value_o == 8'h00)
  `ATP_ASSERT_IMP(a_bad_no_numbers, !empty && out_kind_o == OutFinal && (status_o == StError || status_o == StMalformed), rssi_value_o == 8'h00 && ber_value_o == 8'h00 && attach_value_o == 8'h00)
  `ATP_ASSERT_IMP(a_cfg_always_ready, cfg_valid_i, cfg_ready_o)
  `ATP_ASSERT_NXT(a_head_holds, !empty && !pop, !empty && $stable(out_kind_o) && $stable(status_o) && $stable(char_value_o))

endmodule

bind at_response_parser_core atp_checker u_atp_checker (.*);

[sim/atp_response_checker.sv]
// Response checker for the AT response parser: predicts every result of each byte transfer
// and compares it with the results taken from the block. Depends on atp_pkg only.
module atp_response_checker
  import atp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [2:0] cfg_kind_i,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_start_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic       out_kind_i,
  input  logic [1:0] field_number_i,
  input  logic [4:0] char_pos_i,
  input  logic [7:0] char_value_i,
  input  logic [1:0] status_i,
  input  logic [7:0] rssi_value_i,
  input  logic [7:0] ber_value_i,
  input  logic [7:0] attach_value_i,
  output int         errors_o,
  output int         due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ErrSeq [9] = '{Cr, Lf, "E", "R", "R", "O", "R", Cr, Lf};
  localparam logic [7:0] OkSeq [6] = '{Cr, Lf, "O", "K", Cr, Lf};
  localparam logic [7:0] KindPfx [6][10] = '{
    '{Cr, Lf, "+", "C", "P", "I", "N", ":", " ", Nul},
    '{Cr, Lf, Nul, Nul, Nul, Nul, Nul, Nul, Nul, Nul},
    '{Cr, Lf, "+", "C", "S", "Q", ":", " ", Nul, Nul},
    '{Cr, Lf, "+", "C", "G", "A", "T", "T", ":", " "},
    '{Cr, Lf, "+", "C", "S", "T", "T", ":", " ", Nul},
    '{Cr, Lf, Nul, Nul, Nul, Nul, Nul, Nul, Nul, Nul}
  };
  localparam logic [3:0] KindPfxLen [6] = '{4'd9, 4'd2, 4'd8, 4'd10, 4'd9, 4'd2};

  logic [2:0] kind_reg;
  logic [2:0] act_kind;
  atp_phase_e phase;
  logic [3:0] mpos;
  logic [4:0] fcount;
  logic [1:0] findex;
  logic       err_alive;
  logic [3:0] epos;
  logic [7:0] acc;
  logic [7:0] first_num;

  atp_result_t parser_out_q [$];
  int mismatch_cnt = 0;

  function automatic bit is_num(input logic [7:0] b);
    return b >= Zero && b <= Nine;
  endfunction

  function automatic void add_digit(input logic [7:0] b);
    acc = 8'(acc * 8'd10 + (b - Zero));
  endfunction

  function automatic void close_frame(input atp_status_e st, output atp_result_t res);
    res = '0;
    res.out_kind = OutFinal;
    res.status = st;
    if (st == StOk || st == StNoTrailer) begin
      if (act_kind == KindCsq) begin
        res.rssi_value = first_num;
        res.ber_value = acc;
      end else if (act_kind == KindCgatt) begin
        res.attach_value = acc;
      end
    end
    phase = PhIdle;
  endfunction

  // Returns -1 when the byte breaks the response layout, 1 when a result was written.
  function automatic int kind_path(input logic [7:0] b, output atp_result_t res);
    logic       delim;
    logic [7:0] term;
    res = '0;
    case (phase)
      PhPrefix: begin
        if (act_kind > KindCifsr || mpos >= KindPfxLen[act_kind] ||
            b != KindPfx[act_kind][mpos]) begin
          return -1;
        end
        mpos++;
        if (mpos == KindPfxLen[act_kind]) begin
          mpos = '0;
          acc = '0;
          if (act_kind == KindCsq) begin
            phase = PhNum1;
          end else if (act_kind == KindCgatt) begin
            phase = PhNumG;
          end else begin
            phase = PhField;
            findex = '0;
            fcount = '0;
          end
        end
        return 0;
      end
      PhField: begin
        delim = (b == Nul || b == Comma || b == Cr || b == Lf);
        if (!delim && fcount < FieldMax - 1) begin
          res.out_kind = OutChar;
          res.field_number = findex;
          res.char_pos = fcount;
          res.char_value = b;
          fcount++;
          return 1;
        end
        term = (act_kind == KindCstt && findex < 2) ? Comma : Cr;
        if (b != term) begin
          return -1;
        end
        if (term == Comma) begin
          findex++;
          fcount = '0;
        end else begin
          phase = PhExpLf;
        end
        return 0;
      end
      PhExpLf: begin
        if (b != Lf) begin
          return -1;
        end
        if (act_kind == KindCstt || act_kind == KindCifsr) begin
          close_frame(StNoTrailer, res);
          return 1;
        end
        phase = PhTrailer;
        mpos = '0;
        return 0;
      end
      PhTrailer: begin
        if (mpos >= OkLen || b != OkSeq[mpos]) begin
          return -1;
        end
        mpos++;
        if (mpos == OkLen) begin
          close_frame(StOk, res);
          return 1;
        end
        return 0;
      end
      PhNum1: begin
        if (is_num(b)) begin
          add_digit(b);
          return 0;
        end
        if (b != Comma) begin
          return -1;
        end
        first_num = acc;
        acc = '0;
        phase = PhSpace;
        return 0;
      end
      PhSpace, PhNum2: begin
        if (phase == PhSpace && b == Space) begin
          phase = PhNum2;
          return 0;
        end
        phase = PhNum2;
        if (is_num(b)) begin
          add_digit(b);
          return 0;
        end
        if (b != Cr) begin
          return -1;
        end
        phase = PhExpLf;
        return 0;
      end
      PhNumG: begin
        if (is_num(b)) begin
          add_digit(b);
          return 0;
        end
        close_frame(StNoTrailer, res);
        return 1;
      end
      default: return -1;
    endcase
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic fs,
                                    output atp_result_t res);
    int path;
    res = '0;
    if (fs) begin
      phase = PhPrefix;
      mpos = '0;
      fcount = '0;
      findex = '0;
      err_alive = 1'b1;
      epos = '0;
      acc = '0;
      first_num = '0;
      act_kind = kind_reg;
    end else if (phase == PhIdle) begin
      return 1'b0;
    end
    // The ERROR reply is tracked on every byte and wins over the kind path.
    if (err_alive) begin
      if (epos < ErrLen && b == ErrSeq[epos]) begin
        epos++;
        if (epos >= ErrLen) begin
          close_frame(StError, res);
          return 1'b1;
        end
      end else begin
        err_alive = 1'b0;
      end
    end
    if (phase == PhWaitErr) begin
      if (!err_alive) begin
        close_frame(StMalformed, res);
        return 1'b1;
      end
      return 1'b0;
    end
    path = kind_path(b, res);
    if (path < 0) begin
      if (err_alive) begin
        phase = PhWaitErr;
        return 1'b0;
      end
      close_frame(StMalformed, res);
      return 1'b1;
    end
    return path == 1;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    atp_result_t want;
    atp_result_t res;
    if (!rst_ni) begin
      kind_reg = KindCpin;
      act_kind = KindCpin;
      phase = PhIdle;
      mpos = '0;
      fcount = '0;
      findex = '0;
      err_alive = 1'b1;
      epos = '0;
      acc = '0;
      first_num = '0;
      parser_out_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (parser_out_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0h status %0h char %0h",
                   $time, out_kind_i, status_i, char_value_i);
          mismatch_cnt++;
        end else begin
          want = parser_out_q.pop_front();
          check_field("out_kind", 8'(want.out_kind), 8'(out_kind_i));
          check_field("field_number", 8'(want.field_number), 8'(field_number_i));
          check_field("char_pos", 8'(want.char_pos), 8'(char_pos_i));
          check_field("char_value", want.char_value, char_value_i);
          check_field("status", 8'(want.status), 8'(status_i));
          check_field("rssi_value", want.rssi_value, rssi_value_i);
          check_field("ber_value", want.ber_value, ber_value_i);
          check_field("attach_value", want.attach_value, attach_value_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        kind_reg = cfg_kind_i;
      end
      if (push_i && !full_i) begin
        if (parse_byte(rx_byte_i, frame_start_i, res)) begin
          parser_out_q.push_back(res);
        end
      end
    end
    errors_o <= mismatch_cnt;
    due_o <= parser_out_q.size();
  end

endmodule

[sim/tb_at_response_parser_core.sv]
// Testbench top for at_response_parser_core: drives response bytes, kind writes and result
// pops with random pacing. Depends on atp_pkg, the RTL and atp_response_checker.
module tb_at_response_parser_core;
  timeunit 1ns;
  timeprecision 1ps;
  import atp_pkg::*;

  localparam logic [2:0] KindSpare6 = 3'd6;
  localparam logic [2:0] KindSpare7 = 3'd7;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_kind;
  logic       push;
  logic       full;
  logic [7:0] rx_byte;
  logic       frame_start;
  logic       empty;
  logic       pop;
  logic       out_kind;
  logic [1:0] field_number;
  logic [4:0] char_pos;
  logic [7:0] char_value;
  logic [1:0] status;
  logic [7:0] rssi_value;
  logic [7:0] ber_value;
  logic [7:0] attach_value;
  int         error_total;
  int         due_total;

  bit         hold_req = 1'b0;
  int         burst_left = 0;
  int         sent = 0;
  logic [7:0] frame_bytes [$];

  at_response_parser_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .expected_response_i(cfg_kind),
    .push               (push),
    .full               (full),
    .rx_byte_i          (rx_byte),
    .frame_start_i      (frame_start),
    .empty              (empty),
    .pop                (pop),
    .out_kind_o         (out_kind),
    .field_number_o     (field_number),
    .char_pos_o         (char_pos),
    .char_value_o       (char_value),
    .status_o           (status),
    .rssi_value_o       (rssi_value),
    .ber_value_o        (ber_value),
    .attach_value_o     (attach_value)
  );

  atp_response_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_kind_i    (cfg_kind),
    .push_i        (push),
    .full_i        (full),
    .rx_byte_i     (rx_byte),
    .frame_start_i (frame_start),
    .empty_i       (empty),
    .pop_i         (pop),
    .out_kind_i    (out_kind),
    .field_number_i(field_number),
    .char_pos_i    (char_pos),
    .char_value_i  (char_value),
    .status_i      (status),
    .rssi_value_i  (rssi_value),
    .ber_value_i   (ber_value),
    .attach_value_i(attach_value),
    .errors_o      (error_total),
    .due_o         (due_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_at_response_parser_core: done, errors");
    $finish;
  end

  // The receiver stalls in segments of its own; once it holds off long enough to back up
  // both queues while byte transfers keep coming.
  initial begin
    int mode;
    int seg;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        seg = $urandom_range(1, 40);
        repeat (seg) begin
          case (mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= 1'($urandom_range(0, 1));
            default: pop <= ($urandom_range(0, 5) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fs);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    rx_byte <= b;
    frame_start <= fs;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == 0);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (due_total != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_kind(input logic [2:0] k);
    settle();
    cfg_valid <= 1'b1;
    cfg_kind <= k;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      frame_bytes.push_back(s[i]);
    end
  endtask

  task automatic add_field(input int len);
    logic [7:0] c;
    repeat (len) begin
      do begin
        c = 8'($urandom_range(1, 255));
      end while (c == Comma || c == Cr || c == Lf);
      frame_bytes.push_back(c);
    end
  endtask

  task automatic add_number(input int digits);
    repeat (digits) frame_bytes.push_back(8'($urandom_range(Zero, Nine)));
  endtask

  task automatic send_text(input string s);
    frame_bytes.delete();
    add_text(s);
    send_frame();
  endtask

  function automatic int field_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) begin
      return $urandom_range(0, 6);
    end
    if (r < 19) begin
      return $urandom_range(28, 31);
    end
    return $urandom_range(32, 34);
  endfunction

  task automatic build_response(input logic [2:0] kind);
    logic [7:0] c;
    int cut;
    frame_bytes.delete();
    if ($urandom_range(0, 11) == 0) begin
      add_text("\r\nERROR\r\n");
    end else begin
      case (kind)
        KindCpin: begin
          add_text("\r\n+CPIN: ");
          add_field(field_len());
          add_text("\r\n\r\nOK\r\n");
        end
        KindCcid: begin
          add_text("\r\n");
          add_field(field_len());
          add_text("\r\n\r\nOK\r\n");
        end
        KindCsq: begin
          add_text("\r\n+CSQ: ");
          add_number($urandom_range(0, 4));
          add_text(",");
          if ($urandom_range(0, 1) != 0) begin
            add_text(" ");
          end
          add_number($urandom_range(0, 4));
          add_text("\r\n\r\nOK\r\n");
        end
        KindCgatt: begin
          add_text("\r\n+CGATT: ");
          add_number($urandom_range(0, 4));
          if ($urandom_range(0, 2) != 0) begin
            frame_bytes.push_back(Cr);
          end else begin
            do begin
              c = 8'($urandom_range(0, 255));
            end while (c >= Zero && c <= Nine);
            frame_bytes.push_back(c);
          end
        end
        KindCstt: begin
          add_text("\r\n+CSTT: ");
          add_field(field_len());
          add_text(",");
          add_field(field_len());
          add_text(",");
          add_field(field_len());
          add_text("\r\n");
        end
        KindCifsr: begin
          add_text("\r\n");
          add_field(field_len());
          add_text("\r\n");
        end
        default: begin
          if ($urandom_range(0, 1) != 0) begin
            add_text("\r\nOK\r\n");
          end else begin
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0: frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        if (frame_bytes.size() > 1) begin
          cut = $urandom_range(1, frame_bytes.size() - 1);
          while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end
      end
      2: frame_bytes.insert($urandom_range(0, frame_bytes.size()), 8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  initial begin
    logic [2:0] kind;
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_kind = KindCpin;
    push = 1'b0;
    rx_byte = '0;
    frame_start = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_kind(KindCpin);
    send_text("\r\n+CPIN: READY\r\n\r\nOK\r\n");
    send_text("\r\nERROR\r\n");
    send_byte("x", 1'b0);
    send_text("\r\n+CP");
    send_text("\r\n+CPIN: SIM PIN\r\n\r\nOK\r\n");

    write_kind(KindCcid);
    frame_bytes.delete();
    add_text("\r\n");
    frame_bytes.push_back(8'h01);
    add_field(29);
    frame_bytes.push_back(8'hff);
    add_text("\r\n\r\nOK\r\n");
    send_frame();
    frame_bytes.delete();
    add_text("\r\n");
    add_field(32);
    add_text("\r\n\r\nOK\r\n");
    send_frame();

    write_kind(KindCsq);
    send_text("\r\n+CSQ: 999,255\r\n\r\nOK\r\n");
    send_text("\r\n+CSQ: ,\r\n\r\nOK\r\n");
    send_text("\r\n+CSQ: 12, 7\r\n\r\nOK\r\n");

    write_kind(KindCgatt);
    send_text("\r\n+CGATT: 1\r");
    send_text("\r\nERROR\r\n");
    send_text("\r\nERX\r\n");

    write_kind(KindCstt);
    send_text("\r\n+CSTT: \"CMNET\",\"\",\"\"\r\n");

    write_kind(KindCifsr);
    send_text("\r\n10.0.0.1\r\n");

    write_kind(KindSpare7);
    send_text("\r\nOK\r\n");
    send_text("\r\nERROR\r\n");

    hold_req = 1'b1;
    while (sent < 850) begin
      if ($urandom_range(0, 12) == 0) begin
        kind = $urandom_range(0, 1) != 0 ? KindSpare6 : KindSpare7;
      end else begin
        kind = 3'($urandom_range(KindCpin, KindCifsr));
      end
      write_kind(kind);
      repeat ($urandom_range(3, 10)) begin
        if (sent < 850) begin
          build_response(kind);
          send_frame();
          if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
          end
        end
      end
    end

    settle();
    if (error_total == 0) begin
      $display("tb_at_response_parser_core: done, clean");
    end else begin
      $display("tb_at_response_parser_core: done, errors");
    end
    $finish;
  end

endmodule
